// File: sv/lsrg_pkg.sv
package lsrg_pkg;

  localparam int unsigned MAX_DIM      = 256;
  localparam int unsigned STENCIL_TAPS = 7;
  localparam int unsigned POS_W        = $clog2(MAX_DIM);
  localparam int unsigned DIM_W        = $clog2(MAX_DIM + 1);
  localparam int unsigned PLANE_W      = 2 * DIM_W;

  localparam int unsigned CNT_W    = 9;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned GRID_W   = 24;
  localparam int unsigned ROW_W    = 25;
  localparam int unsigned SLOT_W   = 28;
  localparam int unsigned VALUE_W  = 20;
  localparam int unsigned CFG_W    = 28;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TAP_W    = $clog2(STENCIL_TAPS);

  // row descriptor queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LON_COUNT     = 3'd0,
    CFG_LAT_COUNT     = 3'd1,
    CFG_LAYER_COUNT   = 3'd2,
    CFG_SMOOTH_WEIGHT = 3'd3,
    CFG_FIRST_ROW     = 3'd4,
    CFG_FIRST_SLOT    = 3'd5,
    CFG_SLOT_CAPACITY = 3'd6
  } cfg_idx_e;

  // stencil tap order within an interior row
  localparam logic [TAP_W-1:0] TAP_DIAG     = 3'd0;
  localparam logic [TAP_W-1:0] TAP_LON_DN   = 3'd1;
  localparam logic [TAP_W-1:0] TAP_LON_UP   = 3'd2;
  localparam logic [TAP_W-1:0] TAP_LAT_DN   = 3'd3;
  localparam logic [TAP_W-1:0] TAP_LAT_UP   = 3'd4;
  localparam logic [TAP_W-1:0] TAP_LAYER_DN = 3'd5;
  localparam logic [TAP_W-1:0] TAP_LAYER_UP = 3'd6;

  typedef struct packed {
    logic [CNT_W-1:0]    lon_count;
    logic [CNT_W-1:0]    lat_count;
    logic [CNT_W-1:0]    layer_count;
    logic [WEIGHT_W-1:0] smooth_weight;
    logic [GRID_W-1:0]   first_row;
    logic [SLOT_W-1:0]   first_slot;
    logic [SLOT_W-1:0]   slot_capacity;
  } cfg_t;

  typedef struct packed {
    logic [GRID_W-1:0] grid_index;
    logic [SLOT_W-1:0] slot;
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] row_end;
    logic              boundary;
    logic              done;
    logic              overflow;
  } desc_t;

  // zero acts as one, anything above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CNT_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

// File: sv/laplacian_stencil_csr_row_generator.sv
// Channel    Direction  Handshake           Payload
// request    in         push / full        restart_i
// result     out        empty / pop        slot_o entry_value_o column_o row_o row_end_o
//                                          last_o walk_done_o overflow_o
// config     in         cfg_we_i           cfg_index_i cfg_wdata_i
//
// A boundary or overflowing point yields one result, an interior point seven; the
// back end's tap counter gives one per cycle while no stalled pop holds the output.
// Results pass the row queue, the back end's row register and the output register.
// Requests are taken while the two-deep row queue has room; a halted or finished walk
// swallows requests without restart and gives nothing.
// rst_ni clears the walk and loads register defaults; a stalled pop holds the output
// register, and the back end waits on it without losing a tap.
module laplacian_stencil_csr_row_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lsrg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lsrg_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                push,
  output logic                                full,
  input  logic                                restart_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [lsrg_pkg::SLOT_W-1:0]         slot_o,
  output logic signed [lsrg_pkg::VALUE_W-1:0] entry_value_o,
  output logic [lsrg_pkg::GRID_W-1:0]         column_o,
  output logic [lsrg_pkg::ROW_W-1:0]          row_o,
  output logic [lsrg_pkg::SLOT_W-1:0]         row_end_o,
  output logic                                last_o,
  output logic                                walk_done_o,
  output logic                                overflow_o
);

  lsrg_pkg::cfg_t  cfg_q;
  lsrg_pkg::desc_t front_desc, q_desc;
  logic            front_valid, q_valid, q_pop, accept;

  // register file, index decode; unknown indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lon_count     <= lsrg_pkg::CNT_W'(1);
      cfg_q.lat_count     <= lsrg_pkg::CNT_W'(1);
      cfg_q.layer_count   <= lsrg_pkg::CNT_W'(1);
      cfg_q.smooth_weight <= lsrg_pkg::WEIGHT_W'(256);
      cfg_q.first_row     <= '0;
      cfg_q.first_slot    <= '0;
      cfg_q.slot_capacity <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lsrg_pkg::CFG_LON_COUNT:
          cfg_q.lon_count <= cfg_wdata_i[lsrg_pkg::CNT_W-1:0];
        lsrg_pkg::CFG_LAT_COUNT:
          cfg_q.lat_count <= cfg_wdata_i[lsrg_pkg::CNT_W-1:0];
        lsrg_pkg::CFG_LAYER_COUNT:
          cfg_q.layer_count <= cfg_wdata_i[lsrg_pkg::CNT_W-1:0];
        lsrg_pkg::CFG_SMOOTH_WEIGHT:
          cfg_q.smooth_weight <= cfg_wdata_i[lsrg_pkg::WEIGHT_W-1:0];
        lsrg_pkg::CFG_FIRST_ROW:
          cfg_q.first_row <= cfg_wdata_i[lsrg_pkg::GRID_W-1:0];
        lsrg_pkg::CFG_FIRST_SLOT:
          cfg_q.first_slot <= cfg_wdata_i[lsrg_pkg::SLOT_W-1:0];
        lsrg_pkg::CFG_SLOT_CAPACITY:
          cfg_q.slot_capacity <= cfg_wdata_i[lsrg_pkg::SLOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = push & ~full;

  // front: walk state, boundary and overflow classification
  lsrg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .restart_i    (restart_i),
    .desc_valid_o (front_valid),
    .desc_o       (front_desc)
  );

  // row queue; full back-pressures requests
  lsrg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (front_valid),
    .wdata_i (front_desc),
    .full_o  (full),
    .rd_i    (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_desc)
  );

  // back: expands a row into its taps through the output register
  lsrg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .desc_valid_i  (q_valid),
    .desc_i        (q_desc),
    .desc_pop_o    (q_pop),
    .empty         (empty),
    .pop           (pop),
    .slot_o        (slot_o),
    .entry_value_o (entry_value_o),
    .column_o      (column_o),
    .row_o         (row_o),
    .row_end_o     (row_end_o),
    .last_o        (last_o),
    .walk_done_o   (walk_done_o),
    .overflow_o    (overflow_o)
  );

endmodule

// File: sv/lsrg_front.sv
module lsrg_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsrg_pkg::cfg_t       cfg_i,
  input  logic                 accept_i,
  input  logic                 restart_i,
  output logic                 desc_valid_o,
  output lsrg_pkg::desc_t      desc_o
);

  logic [lsrg_pkg::POS_W-1:0]  lon_pos_q, lon_pos_d, lat_pos_q, lat_pos_d;
  logic [lsrg_pkg::POS_W-1:0]  layer_pos_q, layer_pos_d;
  logic [lsrg_pkg::GRID_W-1:0] grid_q, grid_d, rows_q, rows_d;
  logic [lsrg_pkg::SLOT_W-1:0] nslot_q, nslot_d;
  logic                        halted_q, halted_d, finished_q, finished_d;

  logic [lsrg_pkg::POS_W-1:0]  lon_c, lat_c, layer_c;
  logic [lsrg_pkg::GRID_W-1:0] grid_c, rows_c;
  logic [lsrg_pkg::SLOT_W-1:0] nslot_c, rend;
  logic                        active;
  logic [lsrg_pkg::DIM_W-1:0]  nlon, nlat, nlay;
  logic                        lon_end, lat_end, lay_end, boundary, done, ovf;
  logic [lsrg_pkg::SLOT_W-1:0] taps;
  logic [lsrg_pkg::SLOT_W:0]   need;

  // restart reloads the walk before the point is classified
  assign lon_c   = restart_i ? '0 : lon_pos_q;
  assign lat_c   = restart_i ? '0 : lat_pos_q;
  assign layer_c = restart_i ? '0 : layer_pos_q;
  assign grid_c  = restart_i ? '0 : grid_q;
  assign rows_c  = restart_i ? '0 : rows_q;
  assign nslot_c = restart_i ? cfg_i.first_slot : nslot_q;
  assign active  = restart_i | ~(halted_q | finished_q);

  assign nlon = lsrg_pkg::eff_dim(cfg_i.lon_count);
  assign nlat = lsrg_pkg::eff_dim(cfg_i.lat_count);
  assign nlay = lsrg_pkg::eff_dim(cfg_i.layer_count);

  assign lon_end  = lsrg_pkg::DIM_W'(lon_c)   >= nlon - lsrg_pkg::DIM_W'(1);
  assign lat_end  = lsrg_pkg::DIM_W'(lat_c)   >= nlat - lsrg_pkg::DIM_W'(1);
  assign lay_end  = lsrg_pkg::DIM_W'(layer_c) >= nlay - lsrg_pkg::DIM_W'(1);
  assign boundary = (lon_c == '0) | (lat_c == '0) | (layer_c == '0) |
                    lon_end | lat_end | lay_end;
  assign done     = lon_end & lat_end & lay_end;
  assign taps     = boundary ? lsrg_pkg::SLOT_W'(1)
                             : lsrg_pkg::SLOT_W'(lsrg_pkg::STENCIL_TAPS);
  assign need     = {1'b0, nslot_c} + {1'b0, taps};
  assign ovf      = need > {1'b0, cfg_i.slot_capacity};
  assign rend     = need[lsrg_pkg::SLOT_W-1:0];

  assign desc_valid_o         = accept_i & active;
  assign desc_o.grid_index    = grid_c;
  assign desc_o.slot          = nslot_c;
  assign desc_o.row           = {1'b0, cfg_i.first_row} + {1'b0, rows_c};
  assign desc_o.row_end       = ovf ? nslot_c : rend;
  assign desc_o.boundary      = boundary;
  assign desc_o.done          = done & ~ovf;
  assign desc_o.overflow      = ovf;

  always_comb begin
    lon_pos_d   = lon_pos_q;
    lat_pos_d   = lat_pos_q;
    layer_pos_d = layer_pos_q;
    grid_d      = grid_q;
    rows_d      = rows_q;
    nslot_d     = nslot_q;
    halted_d    = halted_q;
    finished_d  = finished_q;
    if (accept_i) begin
      lon_pos_d   = lon_c;
      lat_pos_d   = lat_c;
      layer_pos_d = layer_c;
      grid_d      = grid_c;
      rows_d      = rows_c;
      nslot_d     = nslot_c;
      halted_d    = halted_q & ~restart_i;
      finished_d  = finished_q & ~restart_i;
      if (active) begin
        if (ovf) begin
          halted_d = 1'b1;
        end else begin
          nslot_d = rend;
          rows_d  = rows_c + lsrg_pkg::GRID_W'(1);
          grid_d  = grid_c + lsrg_pkg::GRID_W'(1);
          if (done) begin
            finished_d = 1'b1;
          end else if (!lon_end) begin
            lon_pos_d = lon_c + lsrg_pkg::POS_W'(1);
          end else begin
            lon_pos_d = '0;
            if (!lat_end) begin
              lat_pos_d = lat_c + lsrg_pkg::POS_W'(1);
            end else begin
              lat_pos_d   = '0;
              layer_pos_d = layer_c + lsrg_pkg::POS_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lon_pos_q   <= '0;
      lat_pos_q   <= '0;
      layer_pos_q <= '0;
      grid_q      <= '0;
      rows_q      <= '0;
      nslot_q     <= '0;
      halted_q    <= 1'b0;
      finished_q  <= 1'b0;
    end else begin
      lon_pos_q   <= lon_pos_d;
      lat_pos_q   <= lat_pos_d;
      layer_pos_q <= layer_pos_d;
      grid_q      <= grid_d;
      rows_q      <= rows_d;
      nslot_q     <= nslot_d;
      halted_q    <= halted_d;
      finished_q  <= finished_d;
    end
  end

endmodule

// File: sv/lsrg_fifo.sv
module lsrg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  lsrg_pkg::desc_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output lsrg_pkg::desc_t rdata_o
);

  localparam int unsigned PTR_W = $clog2(lsrg_pkg::Q_DEPTH);
  localparam int unsigned QCNT_W = $clog2(lsrg_pkg::Q_DEPTH + 1);

  lsrg_pkg::desc_t    mem_q [lsrg_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_wr, do_rd;

  assign full_o  = cnt_q == QCNT_W'(lsrg_pkg::Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

// File: sv/lsrg_back.sv
module lsrg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsrg_pkg::cfg_t                cfg_i,
  input  logic                          desc_valid_i,
  input  lsrg_pkg::desc_t               desc_i,
  output logic                          desc_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [lsrg_pkg::SLOT_W-1:0]   slot_o,
  output logic signed [lsrg_pkg::VALUE_W-1:0] entry_value_o,
  output logic [lsrg_pkg::GRID_W-1:0]   column_o,
  output logic [lsrg_pkg::ROW_W-1:0]    row_o,
  output logic [lsrg_pkg::SLOT_W-1:0]   row_end_o,
  output logic                          last_o,
  output logic                          walk_done_o,
  output logic                          overflow_o
);

  lsrg_pkg::desc_t               desc_q;
  logic                          busy_q, busy_d;
  logic [lsrg_pkg::TAP_W-1:0]    tap_q, tap_d;
  logic                          out_valid_q, out_valid_d;
  logic [lsrg_pkg::PLANE_W-1:0]  plane_q;

  logic                          load_en, emit, is_last;
  logic [lsrg_pkg::VALUE_W-1:0]  w_ext, val;
  logic [lsrg_pkg::GRID_W-1:0]   offset, col;
  logic                          sub;

  assign load_en    = ~out_valid_q | pop;
  assign emit       = busy_q & load_en;
  assign is_last    = desc_q.overflow | desc_q.boundary |
                      (tap_q == lsrg_pkg::TAP_LAYER_UP);
  assign desc_pop_o = desc_valid_i & (~busy_q | (emit & is_last));
  assign empty      = ~out_valid_q;

  assign w_ext = lsrg_pkg::VALUE_W'(cfg_i.smooth_weight);

  always_comb begin
    if (desc_q.overflow) begin
      val = '0;
    end else if (desc_q.boundary) begin
      val = w_ext << 2;
    end else if (tap_q == lsrg_pkg::TAP_DIAG) begin
      val = (w_ext << 2) + (w_ext << 1);
    end else begin
      val = '0 - w_ext;
    end
  end

  always_comb begin
    offset = '0;
    sub    = 1'b0;
    unique case (tap_q)
      lsrg_pkg::TAP_DIAG: begin
        offset = '0;
      end
      lsrg_pkg::TAP_LON_DN: begin
        offset = lsrg_pkg::GRID_W'(1);
        sub    = 1'b1;
      end
      lsrg_pkg::TAP_LON_UP: begin
        offset = lsrg_pkg::GRID_W'(1);
      end
      lsrg_pkg::TAP_LAT_DN: begin
        offset = lsrg_pkg::GRID_W'(lsrg_pkg::eff_dim(cfg_i.lon_count));
        sub    = 1'b1;
      end
      lsrg_pkg::TAP_LAT_UP: begin
        offset = lsrg_pkg::GRID_W'(lsrg_pkg::eff_dim(cfg_i.lon_count));
      end
      lsrg_pkg::TAP_LAYER_DN: begin
        offset = lsrg_pkg::GRID_W'(plane_q);
        sub    = 1'b1;
      end
      lsrg_pkg::TAP_LAYER_UP: begin
        offset = lsrg_pkg::GRID_W'(plane_q);
      end
      default: begin
        offset = '0;
      end
    endcase
  end

  // boundary and overflow rows only ever use the diagonal tap
  assign col = sub ? desc_q.grid_index - offset : desc_q.grid_index + offset;

  always_comb begin
    busy_d      = busy_q;
    tap_d       = tap_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      tap_d       = tap_q + lsrg_pkg::TAP_W'(1);
      if (is_last) begin
        busy_d = 1'b0;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
    if (desc_pop_o) begin
      busy_d = 1'b1;
      tap_d  = lsrg_pkg::TAP_DIAG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      tap_q       <= lsrg_pkg::TAP_DIAG;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plane_q <= lsrg_pkg::eff_dim(cfg_i.lon_count) * lsrg_pkg::eff_dim(cfg_i.lat_count);
    if (desc_pop_o) begin
      desc_q <= desc_i;
    end
    if (emit) begin
      slot_o        <= desc_q.slot + lsrg_pkg::SLOT_W'(tap_q);
      entry_value_o <= val;
      column_o      <= col;
      row_o         <= desc_q.row;
      row_end_o     <= desc_q.row_end;
      last_o        <= is_last;
      walk_done_o   <= desc_q.done;
      overflow_o    <= desc_q.overflow;
    end
  end

endmodule

// File: sv/lsrg_chk.sv
module lsrg_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic [lsrg_pkg::SLOT_W-1:0] slot_o,
  input logic [lsrg_pkg::ROW_W-1:0]  row_o,
  input logic                        last_o,
  input logic                        overflow_o
);

  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overflow_o) |-> last_o)
    else $error("overflow result not marked last");

  a_row_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> (!empty && row_o == $past(row_o)))
    else $error("row broken off mid-way");

  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> (slot_o == $past(slot_o) + lsrg_pkg::SLOT_W'(1)))
    else $error("slot not consecutive within row");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(slot_o)))
    else $error("stalled result changed");

endmodule

bind laplacian_stencil_csr_row_generator lsrg_chk u_lsrg_chk (.*);
